>>> sv/rfo_pkg.sv
// rfo_pkg: shared types and constants of the rectangle fill/outline raster unit
// used by the channel interfaces, the controller, the datapath and the top level
package rfo_pkg;

  // default sizes of the frame store and the fixed-point format
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_FRAC_BITS  = 8;

  // field widths
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 20;
  localparam int CHAR_W   = 8;
  localparam int PIXEL_W  = 9;
  localparam int SIZE_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  // register reset values
  localparam logic [SIZE_W-1:0] FRAME_SIZE_RESET = 10'd512;
  localparam logic [CHAR_W-1:0] BG_CHAR_RESET    = 8'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_CHAR      = 2'd2;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_READ,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic scan_en;
    logic rd_en;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    cmd_t cmd;
    logic size_bad;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/rfo_in_if.sv
// rfo_in_if: command channel of the raster unit, valid/ready plus command payload
// depends on rfo_pkg for field widths
interface rfo_in_if;
  import rfo_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic                       filled;
  logic signed [COORD_W-1:0]  rect_left;
  logic signed [COORD_W-1:0]  rect_top;
  logic signed [COORD_W-1:0]  rect_width;
  logic signed [COORD_W-1:0]  rect_height;
  logic [CHAR_W-1:0]          paint_char;
  logic [PIXEL_W-1:0]         pixel_col;
  logic [PIXEL_W-1:0]         pixel_row;

  modport source (
    output valid, cmd, filled, rect_left, rect_top, rect_width, rect_height,
           paint_char, pixel_col, pixel_row,
    input  ready
  );

  modport sink (
    input  valid, cmd, filled, rect_left, rect_top, rect_width, rect_height,
           paint_char, pixel_col, pixel_row,
    output ready
  );

endinterface

>>> sv/rfo_out_if.sv
// rfo_out_if: result channel of the raster unit, valid/ready plus status and cell
// depends on rfo_pkg for field widths
interface rfo_out_if;
  import rfo_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [CHAR_W-1:0] cell_char;

  modport source (
    output valid, status, cell_char,
    input  ready
  );

  modport sink (
    input  valid, status, cell_char,
    output ready
  );

endinterface

>>> sv/rfo_ctrl.sv
// rfo_ctrl: command sequencer of the raster unit
// depends on rfo_pkg; drives the datapath through ctrl_cmd_t, watches dp_status_t
module rfo_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  rfo_pkg::dp_status_t    status,
  output rfo_pkg::ctrl_cmd_t     ctrl
);
  import rfo_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (status.in_valid) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        // bounds are registered this cycle, dispatch on the held command
        unique case (status.cmd)
          CMD_CLEAR: state_next = ST_SCAN;
          CMD_DRAW:  state_next = status.size_bad ? ST_FINISH : ST_SCAN;
          CMD_READ:  state_next = ST_READ;
          default:   state_next = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        ctrl.scan_en = 1'b1;
        if (status.scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        ctrl.rd_en = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/rfo_datapath.sv
// rfo_datapath: config registers, item hold, scan counters, rectangle test,
// frame store and result register; depends on rfo_pkg and both channel interfaces
module rfo_datapath #(
  parameter int MAX_WIDTH  = rfo_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rfo_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = rfo_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  rfo_in_if.sink                            in_ch,
  rfo_out_if.source                         out_ch,
  input  logic                              cfg_write,
  input  logic [rfo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfo_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  rfo_pkg::ctrl_cmd_t                ctrl,
  output rfo_pkg::dp_status_t               status
);
  import rfo_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = COL_W + ROW_W;
  localparam int DEPTH = 1 << AW;
  localparam int XY_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int PW0   = XY_W + FRAC_BITS + 2;
  localparam int PW    = (PW0 > COORD_W + 2) ? PW0 : COORD_W + 2;
  localparam int CNT_W = 13;
  localparam logic signed [PW-1:0] STEP = PW'(1 << FRAC_BITS);

  // size register value: zero acts as one, above the maximum acts as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end
    return r;
  endfunction

  localparam logic [SIZE_W-1:0] FW_RESET = clamp_size(FRAME_SIZE_RESET, MAX_WIDTH);
  localparam logic [SIZE_W-1:0] FH_RESET = clamp_size(FRAME_SIZE_RESET, MAX_HEIGHT);

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [CHAR_W-1:0] background_char;

  logic [CMD_W-1:0]          cmd_q;
  logic                      filled_q;
  logic signed [COORD_W-1:0] left_q;
  logic signed [COORD_W-1:0] top_q;
  logic signed [COORD_W-1:0] width_q;
  logic signed [COORD_W-1:0] height_q;
  logic [CHAR_W-1:0]         paint_q;
  logic [PIXEL_W-1:0]        pcol_q;
  logic [PIXEL_W-1:0]        prow_q;

  logic signed [PW-1:0] x_lo, x_hi, x_lo_in, x_hi_in;
  logic signed [PW-1:0] y_lo, y_hi, y_lo_in, y_hi_in;
  logic signed [PW-1:0] col_pos, row_pos;

  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic             col_last, row_last;
  logic             is_clear, size_bad, in_frame;
  logic             in_rect, border, wr_en;
  logic [CHAR_W-1:0] wr_data;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] frame_store [0:DEPTH-1];

  logic              out_valid;
  logic              out_status;
  logic [CHAR_W-1:0] out_char;
  logic              accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= FW_RESET;
      frame_height    <= FH_RESET;
      background_char <= BG_CHAR_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_FRAME_WIDTH) begin
        frame_width <= clamp_size(cfg_data, MAX_WIDTH);
      end else if (cfg_index == CFG_FRAME_HEIGHT) begin
        frame_height <= clamp_size(cfg_data, MAX_HEIGHT);
      end else if (cfg_index == CFG_BG_CHAR) begin
        background_char <= cfg_data[CHAR_W-1:0];
      end
    end
  end

  // hold the accepted item
  assign in_ch.ready = ctrl.in_ready;
  assign accept      = in_ch.valid & ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= in_ch.cmd;
      filled_q <= in_ch.filled;
      left_q   <= in_ch.rect_left;
      top_q    <= in_ch.rect_top;
      width_q  <= in_ch.rect_width;
      height_q <= in_ch.rect_height;
      paint_q  <= in_ch.paint_char;
      pcol_q   <= in_ch.pixel_col;
      prow_q   <= in_ch.pixel_row;
    end
  end

  // rectangle bounds, outer and one step in, refreshed from the held item
  always_ff @(posedge clk) begin
    x_lo    <= PW'(left_q);
    x_hi    <= PW'(left_q) + PW'(width_q);
    x_lo_in <= PW'(left_q) + STEP;
    x_hi_in <= PW'(left_q) + PW'(width_q) - STEP;
    y_lo    <= PW'(top_q);
    y_hi    <= PW'(top_q) + PW'(height_q);
    y_lo_in <= PW'(top_q) + STEP;
    y_hi_in <= PW'(top_q) + PW'(height_q) - STEP;
  end

  assign size_bad = (width_q <= 0) || (height_q <= 0);
  assign is_clear = (cmd_q == CMD_CLEAR);

  // scan counters, back to zero at the end of each pass
  assign col_last = (CNT_W'(col_cnt) + CNT_W'(1)) == CNT_W'(frame_width);
  assign row_last = (CNT_W'(row_cnt) + CNT_W'(1)) == CNT_W'(frame_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (ctrl.scan_en) begin
      if (col_last) begin
        col_cnt <= '0;
        row_cnt <= row_last ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // cell position and inside/border test
  assign col_pos = $signed(PW'(col_cnt) << FRAC_BITS);
  assign row_pos = $signed(PW'(row_cnt) << FRAC_BITS);

  assign in_rect = (col_pos >= x_lo) && (col_pos <= x_hi) &&
                   (row_pos >= y_lo) && (row_pos <= y_hi);
  assign border = (col_pos < x_lo_in) || (col_pos > x_hi_in) ||
                  (row_pos < y_lo_in) || (row_pos > y_hi_in);

  assign wr_en   = ctrl.scan_en && (is_clear || (in_rect && (filled_q || border)));
  assign wr_data = is_clear ? background_char : paint_q;
  assign wr_addr = {row_cnt, col_cnt};
  assign rd_addr = {ROW_W'(prow_q), COL_W'(pcol_q)};

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  assign in_frame = ({1'b0, pcol_q} < frame_width) && ({1'b0, prow_q} < frame_height);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_status <= (cmd_q == CMD_DRAW) && size_bad;
      out_char   <= ((cmd_q == CMD_READ) && in_frame) ? rd_data : '0;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.cell_char = out_char;

  // status to the controller
  assign status.in_valid  = in_ch.valid;
  assign status.cmd       = cmd_t'(cmd_q);
  assign status.size_bad  = size_bad;
  assign status.scan_last = col_last && row_last;
  assign status.out_free  = !out_valid || out_ch.ready;

endmodule

>>> sv/rect_fill_outline_raster_unit.sv
// rect_fill_outline_raster_unit: character frame store that clears, paints
// filled or outlined rectangles and reads single cells; depends on rfo_pkg,
// rfo_in_if, rfo_out_if, rfo_ctrl and rfo_datapath
//
// One command is taken at a time and gives one result. Clear and draw sweep
// the frame in use one cell per cycle through the single write port of the
// frame store; a draw with a width or height that is not positive and an
// unknown command skip the sweep, and a read makes one registered memory read.
// The next command is taken as soon as the result is handed to the output
// register, even while that result still waits to be taken. Cells hold no
// reset value: read only cells that a clear or a draw has written.
module rect_fill_outline_raster_unit #(
  parameter int MAX_WIDTH  = rfo_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rfo_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = rfo_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  rfo_in_if.sink                            in_ch,
  rfo_out_if.source                         out_ch,
  input  logic                              cfg_write,
  input  logic [rfo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfo_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rfo_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  // command sequencer
  rfo_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // datapath and frame store
  rfo_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .status    (status)
  );

endmodule

>>> test/tb_rect_fill_outline_raster_unit.sv
// tb_rect_fill_outline_raster_unit: self-checking bench for the rectangle raster unit
// drives commands and register writes, predicts every result and checks the output
// channel; depends on rfo_pkg, rfo_in_if, rfo_out_if and rect_fill_outline_raster_unit
module tb_rect_fill_outline_raster_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rfo_pkg::*;

  localparam int     MAX_W       = DEF_MAX_WIDTH;
  localparam int     MAX_H       = DEF_MAX_HEIGHT;
  localparam int     PIX         = 1 << DEF_FRAC_BITS;
  localparam longint PIXEL_STEP  = longint'(1) << DEF_FRAC_BITS;
  localparam int     CYCLE_LIMIT = 3_000_000;

  // codes the package leaves out
  localparam logic [CMD_W-1:0]     CMD_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam logic [CHAR_W-1:0]    BG_LETTER   = "R";

  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE
  } stall_mode_t;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic                      filled;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] width;
    logic signed [COORD_W-1:0] height;
    logic [CHAR_W-1:0]         paint;
    logic [PIXEL_W-1:0]        col;
    logic [PIXEL_W-1:0]        row;
  } raster_cmd_t;

  typedef struct {
    int                seq;
    logic [CMD_W-1:0]  cmd;
    logic              status;
    logic [CHAR_W-1:0] char_out;
  } raster_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rfo_in_if  in_ch ();
  rfo_out_if out_ch ();

  // predicted frame contents and register copies
  logic [CHAR_W-1:0] frame_model [MAX_W*MAX_H];
  int                model_width;
  int                model_height;
  logic [CHAR_W-1:0] model_bg;

  raster_result_t expected_results [$];
  int error_count    = 0;
  int accepted_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int hold_requests  = 0;
  int hold_length    = 0;

  rect_fill_outline_raster_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic int clamp_extent(logic [CFG_DATA_W-1:0] value, int max_extent);
    if (value == '0) return 1;
    if (int'(value) > max_extent) return max_extent;
    return int'(value);
  endfunction

  function automatic bit covers(longint px, longint py, longint l, longint t,
                                longint w, longint h);
    return px >= l && py >= t && px <= l + w && py <= t + h;
  endfunction

  // works out the result of one command and updates the frame copy
  function automatic raster_result_t predict_raster(raster_cmd_t c);
    raster_result_t r;
    longint l, t, w, h, px, py;
    bit border;
    r.seq = accepted_count;
    r.cmd = c.cmd;
    r.status = 1'b0;
    r.char_out = '0;
    if (c.cmd == CMD_CLEAR) begin
      for (int y = 0; y < model_height; y++)
        for (int x = 0; x < model_width; x++)
          frame_model[y * MAX_W + x] = model_bg;
    end else if (c.cmd == CMD_DRAW) begin
      l = c.left;
      t = c.top;
      w = c.width;
      h = c.height;
      if (w <= 0 || h <= 0) begin
        r.status = 1'b1;
      end else begin
        for (int y = 0; y < model_height; y++) begin
          for (int x = 0; x < model_width; x++) begin
            px = longint'(x) * PIXEL_STEP;
            py = longint'(y) * PIXEL_STEP;
            if (covers(px, py, l, t, w, h)) begin
              border = !covers(px - PIXEL_STEP, py, l, t, w, h) ||
                       !covers(px + PIXEL_STEP, py, l, t, w, h) ||
                       !covers(px, py - PIXEL_STEP, l, t, w, h) ||
                       !covers(px, py + PIXEL_STEP, l, t, w, h);
              if (c.filled || border) frame_model[y * MAX_W + x] = c.paint;
            end
          end
        end
      end
    end else if (c.cmd == CMD_READ) begin
      if (int'(c.col) < model_width && int'(c.row) < model_height)
        r.char_out = frame_model[int'(c.row) * MAX_W + int'(c.col)];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- command builders

  // every field random, so unused fields see both values of every bit
  function automatic raster_cmd_t scrambled_command();
    raster_cmd_t c;
    c.cmd    = CMD_W'($urandom_range(0, 3));
    c.filled = 1'($urandom_range(0, 1));
    c.left   = COORD_W'($urandom);
    c.top    = COORD_W'($urandom);
    c.width  = COORD_W'($urandom);
    c.height = COORD_W'($urandom);
    c.paint  = CHAR_W'($urandom);
    c.col    = PIXEL_W'($urandom);
    c.row    = PIXEL_W'($urandom);
    return c;
  endfunction

  function automatic raster_cmd_t plain_cmd(logic [CMD_W-1:0] cmd);
    raster_cmd_t c;
    c = scrambled_command();
    c.cmd = cmd;
    return c;
  endfunction

  function automatic raster_cmd_t draw_cmd(logic fill, int l, int t, int w, int h,
                                           logic [CHAR_W-1:0] paint);
    raster_cmd_t c;
    c = plain_cmd(CMD_DRAW);
    c.filled = fill;
    c.left   = COORD_W'(l);
    c.top    = COORD_W'(t);
    c.width  = COORD_W'(w);
    c.height = COORD_W'(h);
    c.paint  = paint;
    return c;
  endfunction

  function automatic raster_cmd_t read_cmd(int col, int row);
    raster_cmd_t c;
    c = plain_cmd(CMD_READ);
    c.col = PIXEL_W'(col);
    c.row = PIXEL_W'(row);
    return c;
  endfunction

  // edge a few pixels around the frame in use, whole pixels half the time
  function automatic int near_coord(int extent);
    int v;
    v = int'($urandom_range(0, (extent + 6) * PIX)) - 3 * PIX;
    if ($urandom_range(0, 1)) v = v & ~(PIX - 1);
    return v;
  endfunction

  function automatic int near_extent(int extent);
    if ($urandom_range(0, 1)) return PIX * int'($urandom_range(1, extent + 4));
    return int'($urandom_range(1, (extent + 4) * PIX));
  endfunction

  function automatic raster_cmd_t near_draw();
    return draw_cmd(1'($urandom_range(0, 1)), near_coord(model_width),
                    near_coord(model_height), near_extent(model_width),
                    near_extent(model_height), CHAR_W'($urandom));
  endfunction

  // random mix: mostly drawable rectangles and in-frame reads, some noise
  function automatic raster_cmd_t random_command();
    raster_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      c = plain_cmd(CMD_CLEAR);
    end else if (pick < 50) begin
      c = near_draw();
    end else if (pick < 58) begin
      c = plain_cmd(CMD_DRAW);
    end else if (pick < 62) begin
      c = near_draw();
      if ($urandom_range(0, 1))
        c.width = COORD_W'(-int'($urandom_range(0, 1 << (COORD_W - 1))));
      else
        c.height = COORD_W'(-int'($urandom_range(0, 1 << (COORD_W - 1))));
    end else if (pick < 66) begin
      c = plain_cmd(CMD_UNKNOWN);
    end else if (pick < 92) begin
      c = read_cmd(int'($urandom_range(0, model_width - 1)),
                   int'($urandom_range(0, model_height - 1)));
    end else begin
      c = read_cmd(int'($urandom_range(0, 511)), int'($urandom_range(0, 511)));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic flag_error(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic drive_payload(raster_cmd_t c);
    in_ch.cmd         = c.cmd;
    in_ch.filled      = c.filled;
    in_ch.rect_left   = c.left;
    in_ch.rect_top    = c.top;
    in_ch.rect_width  = c.width;
    in_ch.rect_height = c.height;
    in_ch.paint_char  = c.paint;
    in_ch.pixel_col   = c.col;
    in_ch.pixel_row   = c.row;
  endtask

  // register write; only called while the unit is idle
  task automatic write_register(logic [CFG_IDX_W-1:0] index, int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    case (index)
      CFG_FRAME_WIDTH:  model_width  = clamp_extent(data, MAX_W);
      CFG_FRAME_HEIGHT: model_height = clamp_extent(data, MAX_H);
      CFG_BG_CHAR:      model_bg     = data[CHAR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // offer one item in bursts with random gaps, predict it once taken
  task automatic send_item(raster_cmd_t c);
    int gap;
    raster_result_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    drive_payload(c);
    do @(posedge clk); while (!in_ch.ready);
    r = predict_raster(c);
    accepted_count++;
    expected_results.push_back(r);
  endtask

  // sender pauses until every predicted result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  // whole 512 x 512 frame at reset settings: clear, big outline, corner reads
  task automatic test_full_frame();
    send_item(plain_cmd(CMD_CLEAR));
    send_item(draw_cmd(1'b0, 300 * PIX + 128, 3 * PIX - 100, 211 * PIX + 200, 600 * PIX, "#"));
    send_item(read_cmd(301, 3));
    send_item(read_cmd(511, 511));
    send_item(read_cmd(0, 0));
  endtask

  // size registers at and beyond their limits, unused index ignored
  task automatic test_register_extremes();
    drain_results();
    write_register(CFG_FRAME_WIDTH, 0);
    write_register(CFG_FRAME_HEIGHT, 1023);
    write_register(CFG_BG_CHAR, 1023);
    send_item(plain_cmd(CMD_CLEAR));
    send_item(draw_cmd(1'b1, -PIX, 100 * PIX, 2 * PIX, 50 * PIX, 8'h00));
    send_item(read_cmd(0, 120));
    send_item(read_cmd(0, 511));
    send_item(read_cmd(1, 0));
    drain_results();
    write_register(CFG_FRAME_WIDTH, 1023);
    write_register(CFG_FRAME_HEIGHT, 0);
    write_register(CFG_BG_CHAR, 0);
    write_register(CFG_UNUSED, 'h2AA);
    send_item(plain_cmd(CMD_CLEAR));
    send_item(read_cmd(511, 0));
    send_item(read_cmd(0, 1));
  endtask

  // small frame: fractional outline, bad sizes, offscreen and tiny rectangles
  task automatic test_directed_draws();
    drain_results();
    write_register(CFG_FRAME_WIDTH, 16);
    write_register(CFG_FRAME_HEIGHT, 12);
    write_register(CFG_BG_CHAR, int'(BG_LETTER));
    send_item(plain_cmd(CMD_CLEAR));
    send_item(draw_cmd(1'b0, 2 * PIX + 128, PIX, 9 * PIX + 192, 6 * PIX, "*"));
    send_item(draw_cmd(1'b1, 0, 0, 0, 5 * PIX, "!"));
    send_item(draw_cmd(1'b1, PIX, PIX, 3 * PIX, -524288, "!"));
    send_item(draw_cmd(1'b1, 524287, 524287, 524287, 1, "$"));
    send_item(draw_cmd(1'b1, -524288, -524288, 524287, 524287, "%"));
    send_item(draw_cmd(1'b0, 4 * PIX, 5 * PIX, 1, 1, "@"));
    send_item(plain_cmd(CMD_UNKNOWN));
    send_item(read_cmd(3, 1));
    send_item(read_cmd(5, 4));
    send_item(read_cmd(4, 5));
    send_item(read_cmd(15, 11));
  endtask

  // receiver holds off long while items keep coming, so the input stalls
  task automatic test_backpressure();
    drain_results();
    write_register(CFG_FRAME_WIDTH, 8);
    write_register(CFG_FRAME_HEIGHT, 8);
    hold_length = 800;
    hold_requests++;
    burst_left = 12;
    repeat (10) send_item(random_command());
    drain_results();
  endtask

  // several frame settings, random command mix in each
  task automatic test_random_phases();
    int widths[5]  = '{24, 1, 3, 512, 0};
    int heights[5] = '{16, 1, 60, 2, 0};
    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_register(CFG_FRAME_WIDTH,
                     widths[p] != 0 ? widths[p] : int'($urandom_range(1, 40)));
      write_register(CFG_FRAME_HEIGHT,
                     heights[p] != 0 ? heights[p] : int'($urandom_range(1, 40)));
      write_register(CFG_BG_CHAR, int'($urandom_range(0, 1023)));
      repeat (13) send_item(random_command());
    end
  endtask

  // ---------------------------------------------------------------- processes

  // result receiver: stall pattern of its own plus requested long hold-offs
  initial begin : result_receiver
    stall_mode_t mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    out_ch.ready = 1'b0;
    mode = RX_STREAM;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = hold_length;
      end
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (mode)
          RX_STREAM: out_ch.ready = 1'b1;
          RX_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
          default:   out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : result_checker
    raster_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result with nothing pending: status %0b char %0d",
                             out_ch.status, out_ch.cell_char));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          flag_error($sformatf("item %0d cmd %0d: status %0b, predicted %0b",
                               want.seq, want.cmd, out_ch.status, want.status));
        if (out_ch.cell_char !== want.char_out)
          flag_error($sformatf("item %0d cmd %0d: cell_char %0d, predicted %0d",
                               want.seq, want.cmd, out_ch.cell_char, want.char_out));
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    raster_cmd_t idle_item;
    idle_item = '{default: '0};
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    drive_payload(idle_item);
    model_width = clamp_extent(FRAME_SIZE_RESET, MAX_W);
    model_height = clamp_extent(FRAME_SIZE_RESET, MAX_H);
    model_bg = BG_CHAR_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_full_frame();
    test_register_extremes();
    test_directed_draws();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> rect_fill_outline_raster_unit.f
sv/rfo_pkg.sv
sv/rfo_in_if.sv
sv/rfo_out_if.sv
sv/rfo_ctrl.sv
sv/rfo_datapath.sv
sv/rect_fill_outline_raster_unit.sv
test/tb_rect_fill_outline_raster_unit.sv
